// ===== hw/rtl/lre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lre_pkg;

  // Datapath and character widths.
  localparam int unsigned LRE_DATA_W    = 32;
  localparam int unsigned LRE_CH_W      = 8;
  localparam int unsigned LRE_DIGIT_W   = 4;
  localparam int unsigned LRE_MAX_CHARS = 32;

  // Configuration port.
  localparam int unsigned LRE_PADDR_W = 3;
  localparam int unsigned LRE_PDATA_W = 32;
  localparam logic [0:0]  LRE_REG_EVAL_ENABLE = 1'b0;

  // Characters of interest.
  localparam logic [LRE_CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [LRE_CH_W-1:0] CH_0     = 8'h30;
  localparam logic [LRE_CH_W-1:0] CH_9     = 8'h39;
  localparam logic [LRE_CH_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [LRE_CH_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [LRE_CH_W-1:0] CH_STAR  = 8'h2a;
  localparam logic [LRE_CH_W-1:0] CH_LX    = 8'h78;
  localparam logic [LRE_CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [LRE_CH_W-1:0] CH_SLASH = 8'h2f;
  localparam logic [LRE_CH_W-1:0] CH_EQ    = 8'h3d;

  // Accumulator update selected by the controller.
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_DIGIT,
    ACC_APPEND,
    ACC_ADD,
    ACC_SUB,
    ACC_MUL,
    ACC_QUOT
  } lre_acc_e;

  // Operand update selected by the controller.
  typedef enum logic [1:0] {
    OPND_HOLD,
    OPND_DIGIT,
    OPND_APPEND
  } lre_opnd_e;

  typedef struct packed {
    lre_acc_e                acc_cmd;
    lre_opnd_e               opnd_cmd;
    logic [LRE_DIGIT_W-1:0]  digit;
    logic                    div_start;
    logic                    out_load;
    logic                    out_ok;
    logic                    out_zero;
  } lre_cmd_t;

  typedef struct packed {
    logic opnd_zero;
    logic div_done;
  } lre_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lre_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Character channel: one beat carries one character.
interface lre_in_if;
  logic                         valid;
  logic                         ready;
  logic [lre_pkg::LRE_CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

// Result channel: one beat carries one evaluation result.
interface lre_res_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  ok;
  logic signed [lre_pkg::LRE_DATA_W-1:0] value;

  modport source (output valid, output ok, output value, input ready);
  modport sink (input valid, input ok, input value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lre_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Unsigned restoring divider, one quotient bit per cycle.
module lre_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [lre_pkg::LRE_DATA_W-1:0] dividend_i,
  input  wire logic [lre_pkg::LRE_DATA_W-1:0] divisor_i,
  output logic                                done_o,
  output logic [lre_pkg::LRE_DATA_W-1:0]      quotient_o
);
  import lre_pkg::*;

  localparam int unsigned CntW = $clog2(LRE_DATA_W);
  localparam logic [CntW-1:0] CntLast = CntW'(LRE_DATA_W - 1);

  logic [LRE_DATA_W-1:0] rem_q, rem_d;
  logic [LRE_DATA_W-1:0] quo_q, quo_d;
  logic [LRE_DATA_W-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [LRE_DATA_W:0]   shifted;
  logic [LRE_DATA_W:0]   diff;

  // The remainder stays below the divisor, so it always fits one word.
  assign shifted = {rem_q, quo_q[LRE_DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[LRE_DATA_W]) begin
        rem_d = diff[LRE_DATA_W-1:0];
        quo_d = {quo_q[LRE_DATA_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[LRE_DATA_W-1:0];
        quo_d = {quo_q[LRE_DATA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lre_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Accumulator, operand, arithmetic units and result register.
module lre_dp (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire lre_pkg::lre_cmd_t                     cmd_i,
  output lre_pkg::lre_sts_t                          sts_o,
  output logic                                       out_ok_o,
  output logic signed [lre_pkg::LRE_DATA_W-1:0]      out_value_o
);
  import lre_pkg::*;

  logic [LRE_DATA_W-1:0] acc_q, acc_d;
  logic [LRE_DATA_W-1:0] opnd_q, opnd_d;
  logic                  neg_q;
  logic [LRE_DATA_W-1:0] acc_mag;
  logic [LRE_DATA_W-1:0] opnd_mag;
  logic [LRE_DATA_W-1:0] quotient;
  logic                  div_done;
  logic [LRE_DATA_W-1:0] digit_ext;
  logic                  out_ok_q;
  logic [LRE_DATA_W-1:0] out_value_q;

  // Decimal shift-in: v * 10 + d, wrapping, built from two shifts.
  function automatic logic [LRE_DATA_W-1:0] shift_in(input logic [LRE_DATA_W-1:0] v,
                                                     input logic [LRE_DATA_W-1:0] d);
    shift_in = (v << 3) + (v << 1) + d;
  endfunction

  assign digit_ext = LRE_DATA_W'(cmd_i.digit);
  assign acc_mag   = acc_q[LRE_DATA_W-1] ? (-acc_q) : acc_q;
  assign opnd_mag  = opnd_q[LRE_DATA_W-1] ? (-opnd_q) : opnd_q;

  lre_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_mag),
    .divisor_i  (opnd_mag),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    acc_d = acc_q;
    unique case (cmd_i.acc_cmd)
      ACC_HOLD:   acc_d = acc_q;
      ACC_CLEAR:  acc_d = '0;
      ACC_DIGIT:  acc_d = digit_ext;
      ACC_APPEND: acc_d = shift_in(acc_q, digit_ext);
      ACC_ADD:    acc_d = acc_q + opnd_q;
      ACC_SUB:    acc_d = acc_q - opnd_q;
      ACC_MUL:    acc_d = acc_q * opnd_q;
      ACC_QUOT:   acc_d = neg_q ? (-quotient) : quotient;
      default:    acc_d = acc_q;
    endcase
  end

  always_comb begin
    opnd_d = opnd_q;
    unique case (cmd_i.opnd_cmd)
      OPND_HOLD:   opnd_d = opnd_q;
      OPND_DIGIT:  opnd_d = digit_ext;
      OPND_APPEND: opnd_d = shift_in(opnd_q, digit_ext);
      default:     opnd_d = opnd_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    if (cmd_i.div_start) begin
      neg_q <= acc_q[LRE_DATA_W-1] ^ opnd_q[LRE_DATA_W-1];
    end
    if (cmd_i.out_load) begin
      out_ok_q    <= cmd_i.out_ok;
      out_value_q <= cmd_i.out_zero ? '0 : acc_q;
    end
  end

  assign sts_o.opnd_zero = (opnd_q == '0);
  assign sts_o.div_done  = div_done;
  assign out_ok_o        = out_ok_q;
  assign out_value_o     = out_value_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lre_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Parsing state machine and handshake control.
module lre_ctrl #(
  parameter int unsigned MAX_CHARS = lre_pkg::LRE_MAX_CHARS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic [lre_pkg::LRE_CH_W-1:0] in_ch_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  input  wire logic                         eval_enable_i,
  input  wire lre_pkg::lre_sts_t            sts_i,
  output lre_pkg::lre_cmd_t                 cmd_o
);
  import lre_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_CHARS);
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_CHARS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_NUM1  = 3'd1;
  localparam logic [2:0] PH_OPND  = 3'd2;
  localparam logic [2:0] PH_NUM2  = 3'd3;
  localparam logic [2:0] PH_EQ    = 3'd4;
  localparam logic [2:0] PH_FAIL  = 3'd5;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [2:0]      phase_q, phase_d;
  logic [1:0]      op_q, op_d;
  logic            unk_q, unk_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ok_q, ok_d;
  logic            term_q, term_d;
  logic [2:0]      sv_phase_q, sv_phase_d;
  logic [1:0]      sv_op_q, sv_op_d;
  logic            sv_unk_q, sv_unk_d;
  logic            out_valid_q, out_valid_d;

  logic       accept;
  logic       term;
  logic       is_dig;
  logic [2:0] al_phase;
  logic [1:0] al_op;
  logic       al_unk;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign term       = (in_ch_i == CH_NUL);
  assign is_dig     = (in_ch_i >= CH_0) && (in_ch_i <= CH_9);

  // What a non-digit after a complete literal does.
  always_comb begin
    al_phase = PH_OPND;
    al_op    = OP_ADD;
    al_unk   = 1'b0;
    unique case (in_ch_i) inside
      CH_EQ: begin
        al_phase = PH_EQ;
        al_op    = op_q;
        al_unk   = unk_q;
      end
      CH_PLUS:               al_op = OP_ADD;
      CH_MINUS:              al_op = OP_SUB;
      CH_STAR, CH_LX, CH_UX: al_op = OP_MUL;
      CH_SLASH:              al_op = OP_DIV;
      default:               al_unk = 1'b1;
    endcase
  end

  always_comb begin
    logic apply_req;
    logic apply_succ;
    logic apply_fail;

    apply_req   = 1'b0;
    apply_succ  = 1'b0;
    apply_fail  = 1'b0;
    state_d     = state_q;
    phase_d     = phase_q;
    op_d        = op_q;
    unk_d       = unk_q;
    cnt_d       = cnt_q;
    ok_d        = ok_q;
    term_d      = term_q;
    sv_phase_d  = sv_phase_q;
    sv_op_d     = sv_op_q;
    sv_unk_d    = sv_unk_q;
    out_valid_d = out_valid_q;

    cmd_o           = '0;
    cmd_o.acc_cmd   = ACC_HOLD;
    cmd_o.opnd_cmd  = OPND_HOLD;
    cmd_o.digit     = LRE_DIGIT_W'(in_ch_i - CH_0);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (term) begin
            unique case (phase_q) inside
              PH_NUM1, PH_EQ: begin
                ok_d    = 1'b1;
                state_d = ST_FIN;
              end
              PH_NUM2: apply_req = 1'b1;
              default: begin
                ok_d    = 1'b0;
                state_d = ST_FIN;
              end
            endcase
          end else if (cnt_q != CntLast) begin
            cnt_d = cnt_q + 1'b1;
            unique case (phase_q)
              PH_FIRST: begin
                if (is_dig) begin
                  cmd_o.acc_cmd = ACC_DIGIT;
                  phase_d       = PH_NUM1;
                end else begin
                  phase_d = PH_FAIL;
                end
              end
              PH_NUM1: begin
                if (is_dig) begin
                  cmd_o.acc_cmd = ACC_APPEND;
                end else begin
                  phase_d = al_phase;
                  op_d    = al_op;
                  unk_d   = al_unk;
                end
              end
              PH_OPND: begin
                if (is_dig) begin
                  cmd_o.opnd_cmd = OPND_DIGIT;
                  phase_d        = PH_NUM2;
                end else begin
                  phase_d = PH_FAIL;
                end
              end
              PH_NUM2: begin
                if (is_dig) begin
                  cmd_o.opnd_cmd = OPND_APPEND;
                end else begin
                  apply_req = 1'b1;
                end
              end
              PH_EQ:   phase_d = PH_FAIL;
              default: phase_d = phase_q;
            endcase
          end

          if (apply_req) begin
            if (unk_q) begin
              apply_fail = 1'b1;
            end else begin
              unique case (op_q)
                OP_ADD: begin
                  cmd_o.acc_cmd = ACC_ADD;
                  apply_succ    = 1'b1;
                end
                OP_SUB: begin
                  cmd_o.acc_cmd = ACC_SUB;
                  apply_succ    = 1'b1;
                end
                OP_MUL: begin
                  cmd_o.acc_cmd = ACC_MUL;
                  apply_succ    = 1'b1;
                end
                default: begin
                  if (sts_i.opnd_zero) begin
                    apply_fail = 1'b1;
                  end else begin
                    cmd_o.div_start = 1'b1;
                    term_d          = term;
                    sv_phase_d      = al_phase;
                    sv_op_d         = al_op;
                    sv_unk_d        = al_unk;
                    state_d         = ST_DIV;
                  end
                end
              endcase
            end
          end

          if (apply_succ) begin
            if (term) begin
              ok_d    = 1'b1;
              state_d = ST_FIN;
            end else begin
              phase_d = al_phase;
              op_d    = al_op;
              unk_d   = al_unk;
            end
          end

          if (apply_fail) begin
            if (term) begin
              ok_d    = 1'b0;
              state_d = ST_FIN;
            end else begin
              phase_d = PH_FAIL;
            end
          end
        end
      end

      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.acc_cmd = ACC_QUOT;
          if (term_q) begin
            ok_d    = 1'b1;
            state_d = ST_FIN;
          end else begin
            phase_d = sv_phase_q;
            op_d    = sv_op_q;
            unk_d   = sv_unk_q;
            state_d = ST_IDLE;
          end
        end
      end

      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_ok   = ok_q && eval_enable_i;
          cmd_o.out_zero = !eval_enable_i;
          cmd_o.acc_cmd  = ACC_CLEAR;
          out_valid_d    = 1'b1;
          phase_d        = PH_FIRST;
          op_d           = OP_ADD;
          unk_d          = 1'b0;
          cnt_d          = '0;
          state_d        = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FIRST;
      op_q        <= OP_ADD;
      unk_q       <= 1'b0;
      cnt_q       <= '0;
      ok_q        <= 1'b0;
      term_q      <= 1'b0;
      sv_phase_q  <= PH_FIRST;
      sv_op_q     <= OP_ADD;
      sv_unk_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      op_q        <= op_d;
      unk_q       <= unk_d;
      cnt_q       <= cnt_d;
      ok_q        <= ok_d;
      term_q      <= term_d;
      sv_phase_q  <= sv_phase_d;
      sv_op_q     <= sv_op_d;
      sv_unk_q    <= sv_unk_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/left_to_right_expression_evaluator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Left-to-right expression evaluator. Characters arrive one per beat on the
// input channel; decimal literals are built up and the operators + - * x X /
// are applied strictly in order of arrival, with no precedence, in wrapping
// 32-bit arithmetic, division truncating towards zero. One '=' may close the
// text. A zero character ends the expression and yields exactly one result
// beat carrying ok and value; value is the accumulator as it stood before any
// failing step. Characters beyond MAX_CHARS-1 in one expression are ignored.
// Digits and the operators + - * are handled as they arrive, the multiply done
// combinationally into the accumulator register. An operator that follows a
// divide waits for the one-bit-per-cycle restoring divider: a start, one
// iteration per quotient bit, and a write-back of the quotient. The terminator
// waits for a pending divide in the same way, then passes through a finishing
// state that waits for the result register to empty. Ordinary characters are
// still accepted while a finished result waits in that register. The
// eval_enable register (byte address 0, reset 1) forces ok=0 and value=0 when
// cleared; it is sampled as the result is produced.
module left_to_right_expression_evaluator #(
  parameter int unsigned MAX_CHARS = lre_pkg::LRE_MAX_CHARS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  lre_in_if.sink                               in_i,
  lre_res_if.source                            res_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lre_pkg::LRE_PADDR_W-1:0] paddr,
  input  wire logic [lre_pkg::LRE_PDATA_W-1:0] pwdata,
  output logic [lre_pkg::LRE_PDATA_W-1:0]      prdata,
  output logic                                 pready
);
  import lre_pkg::*;

  logic     eval_enable_q, eval_enable_d;
  logic     reg_sel;
  lre_cmd_t cmd;
  lre_sts_t sts;

  // The register file is one word; the upper address bit picks the word and
  // the byte-lane bits below it are ignored.
  assign reg_sel = (paddr[LRE_PADDR_W-1:2] == LRE_REG_EVAL_ENABLE);
  assign pready  = 1'b1;

  always_comb begin
    eval_enable_d = eval_enable_q;
    if (psel && penable && pwrite && reg_sel) begin
      eval_enable_d = pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = LRE_PDATA_W'(eval_enable_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_enable_q <= 1'b1;
    end else begin
      eval_enable_q <= eval_enable_d;
    end
  end

  // The controller owns the parse state and both handshakes; the datapath
  // only does what each cycle's command tells it.
  lre_ctrl #(
    .MAX_CHARS (MAX_CHARS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ch_i       (in_i.ch),
    .in_ready_o    (in_i.ready),
    .out_valid_o   (res_o.valid),
    .out_ready_i   (res_o.ready),
    .eval_enable_i (eval_enable_q),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  lre_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ok_o    (res_o.ok),
    .out_value_o (res_o.value)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/lre_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lre_chk (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic [lre_pkg::LRE_CH_W-1:0]   in_ch,
  input wire logic                           res_valid,
  input wire logic                           res_ready,
  input wire logic                           res_ok,
  input wire logic [lre_pkg::LRE_DATA_W-1:0] res_value
);
  import lre_pkg::*;

  // A stalled result beat holds its payload.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_ok) && $stable(res_value))
    else $error("result beat changed while stalled");

  // A terminator is never followed directly by another accepted character.
  a_term_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_ch == CH_NUL) |=> !in_ready)
    else $error("input accepted directly after a terminator");

  // An ordinary character never produces a result.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_ch != CH_NUL) && !res_valid |=> !res_valid)
    else $error("result produced by a non-terminator");

  // A result only rises right after input was held off.
  a_res_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid) |-> $past(!in_ready))
    else $error("result appeared without a finishing cycle");

endmodule

bind left_to_right_expression_evaluator lre_chk u_lre_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_ch     (in_i.ch),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .res_ok    (res_o.ok),
  .res_value (res_o.value)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import lre_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  // The pause before a register write, and at the end of the run, leaves a
  // margin over the time that a terminator after a divide needs.
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 600000;
  // Only this many characters of one expression are taken. Any further
  // characters are dropped until the terminator.
  localparam int TEXT_ROOM     = LRE_MAX_CHARS - 1;

  // Where the scanner stands within the current expression.
  typedef enum logic [2:0] {
    SCAN_FIRST,  // waiting for the first digit
    SCAN_LIT1,   // inside the first literal
    SCAN_OPND,   // operator seen, waiting for an operand digit
    SCAN_LIT2,   // inside an operand literal
    SCAN_EQ,     // after the closing '='
    SCAN_DEAD    // failed, everything up to the terminator is dropped
  } scan_e;

  typedef enum logic [1:0] {
    ARITH_ADD,
    ARITH_SUB,
    ARITH_MUL,
    ARITH_DIV
  } arith_e;

  typedef struct packed {
    logic                  ok;
    logic [LRE_DATA_W-1:0] value;
  } verdict_t;

  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [LRE_PADDR_W-1:0] paddr;
  logic [LRE_PDATA_W-1:0] pwdata;
  logic [LRE_PDATA_W-1:0] prdata;
  logic                   pready;

  lre_in_if  char_bus ();
  lre_res_if result_bus ();

  left_to_right_expression_evaluator u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (char_bus),
    .res_o   (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // The evaluator as the testbench sees it. This is the scan state, the pending
  // operator, accumulator, operand, text length and the enable register as last written.
  scan_e                 scan;
  arith_e                pending_op;
  logic                  op_unknown;
  logic [LRE_DATA_W-1:0] acc;
  logic [LRE_DATA_W-1:0] opnd;
  int                    text_len;
  logic                  eval_en;

  logic [LRE_CH_W-1:0] char_queue[$];  // characters still to be sent
  logic [LRE_CH_W-1:0] draft[$];       // expression being composed
  verdict_t            pending_verdicts[$];
  verdict_t            want;

  logic in_fire = 1'b0;
  int   src_idle_pct  = 33;
  int   sink_idle_pct = 85;
  int   cycle_count   = 0;
  int   errors        = 0;
  int   n_chars       = 0;
  int   n_results     = 0;
  int   n_ok          = 0;
  int   n_disabled    = 0;

  function automatic void restart_expression();
    scan       = SCAN_FIRST;
    acc        = '0;
    opnd       = '0;
    pending_op = ARITH_ADD;
    op_unknown = 1'b0;
    text_len   = 0;
  endfunction

  // Signed division truncating towards zero, done on magnitudes. This way the
  // most negative value over minus one wraps back to itself, as the
  // hardware does.
  function automatic logic [LRE_DATA_W-1:0] quotient(logic [LRE_DATA_W-1:0] a,
                                                     logic [LRE_DATA_W-1:0] b);
    logic [LRE_DATA_W-1:0] ma;
    logic [LRE_DATA_W-1:0] mb;
    logic [LRE_DATA_W-1:0] q;
    ma = a[LRE_DATA_W-1] ? '0 - a : a;
    mb = b[LRE_DATA_W-1] ? '0 - b : b;
    q  = ma / mb;
    return (a[LRE_DATA_W-1] ^ b[LRE_DATA_W-1]) ? '0 - q : q;
  endfunction

  // Folds the finished operand into the accumulator. It returns 0 when the
  // step fails, and then the accumulator keeps its old value.
  function automatic logic fold_operand();
    if (op_unknown) begin
      return 1'b0;
    end
    case (pending_op)
      ARITH_ADD: acc = acc + opnd;
      ARITH_SUB: acc = acc - opnd;
      ARITH_MUL: acc = acc * opnd;
      default: begin
        if (opnd == '0) begin
          return 1'b0;
        end
        acc = quotient(acc, opnd);
      end
    endcase
    return 1'b1;
  endfunction

  // Handles a non-digit that follows a complete literal. An unknown operator
  // is only noted here; it fails when the operand after it is folded in.
  function automatic void open_operator(logic [LRE_CH_W-1:0] c);
    if (c == CH_EQ) begin
      scan = SCAN_EQ;
      return;
    end
    op_unknown = 1'b0;
    pending_op = ARITH_ADD;
    if (c == CH_MINUS) begin
      pending_op = ARITH_SUB;
    end else if (c == CH_STAR || c == CH_LX || c == CH_UX) begin
      pending_op = ARITH_MUL;
    end else if (c == CH_SLASH) begin
      pending_op = ARITH_DIV;
    end else if (c != CH_PLUS) begin
      op_unknown = 1'b1;
    end
    scan = SCAN_OPND;
  endfunction

  // Advances the state by one accepted character. A terminator also queues
  // the result that the block must return for the expression.
  function automatic void take_char(logic [LRE_CH_W-1:0] c);
    logic                  is_digit;
    logic [LRE_DATA_W-1:0] d;
    logic                  ok;
    verdict_t              v;
    is_digit = (c >= CH_0) && (c <= CH_9);
    d        = is_digit ? LRE_DATA_W'(c - CH_0) : '0;
    if (c == CH_NUL) begin
      case (scan) inside
        SCAN_LIT1, SCAN_EQ: ok = 1'b1;
        SCAN_LIT2:          ok = fold_operand();
        default:            ok = 1'b0;
      endcase
      v.ok    = eval_en & ok;
      v.value = eval_en ? acc : '0;
      pending_verdicts.push_back(v);
      n_ok       += v.ok;
      n_disabled += !eval_en;
      restart_expression();
    end else if (text_len < TEXT_ROOM) begin
      text_len++;
      case (scan)
        SCAN_FIRST: begin
          acc  = d;
          scan = is_digit ? SCAN_LIT1 : SCAN_DEAD;
        end
        SCAN_LIT1: begin
          if (is_digit) begin
            acc = acc * 10 + d;
          end else begin
            open_operator(c);
          end
        end
        SCAN_OPND: begin
          opnd = d;
          scan = is_digit ? SCAN_LIT2 : SCAN_DEAD;
        end
        SCAN_LIT2: begin
          if (is_digit) begin
            opnd = opnd * 10 + d;
          end else if (!fold_operand()) begin
            scan = SCAN_DEAD;
          end else begin
            open_operator(c);
          end
        end
        SCAN_EQ: scan = SCAN_DEAD;
        default: ;
      endcase
    end
  endfunction

  // Stimulus helpers.
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      draft.push_back(s[i]);
    end
  endfunction

  function automatic void add_literal();
    int digits;
    digits = ($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(3, 1);
    repeat (digits) begin
      draft.push_back(CH_0 + LRE_CH_W'($urandom_range(9)));
    end
  endfunction

  function automatic logic [LRE_CH_W-1:0] pick_operator();
    case ($urandom_range(5))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_LX;
      4:       return CH_UX;
      default: return CH_SLASH;
    endcase
  endfunction

  // Sends the draft plus its terminator. It returns how many characters the
  // block will actually take, without those dropped past the length limit.
  function automatic int commit_draft();
    foreach (draft[i]) begin
      char_queue.push_back(draft[i]);
    end
    char_queue.push_back(CH_NUL);
    return ((draft.size() < TEXT_ROOM) ? draft.size() : TEXT_ROOM) + 1;
  endfunction

  // Random expressions. Most of them are well formed, so that they reach
  // the arithmetic. The rest are corner templates, well formed text that has
  // been broken, and plain noise. Now and then an expression runs past the
  // length limit.
  task automatic fill_random(input int target);
    int made;
    int pick;
    int terms;
    int spot;
    made = 0;
    while (made < target) begin
      draft.delete();
      pick = $urandom_range(99);
      if (pick < 8) begin
        case ($urandom_range(3))
          0:       add_text("2147483648/4294967295=");
          1:       add_text("0-2147483648/4294967295");
          2:       add_text("7/4294967296");
          default: add_text("4294967295x4294967295+1");
        endcase
      end else if (pick < 93) begin
        add_literal();
        terms = ($urandom_range(7) == 0) ? $urandom_range(12, 6) : $urandom_range(4, 1);
        repeat (terms) begin
          draft.push_back(pick_operator());
          if (draft[$] == CH_SLASH && $urandom_range(4) == 0) begin
            draft.push_back(CH_0);
          end else begin
            add_literal();
          end
        end
        if ($urandom_range(1) == 1) begin
          draft.push_back(CH_EQ);
        end
        if (pick >= 78) begin
          spot = $urandom_range(draft.size() - 1);
          case ($urandom_range(3))
            0: draft[spot] = LRE_CH_W'($urandom_range(255, 1));
            1: draft.insert(spot, LRE_CH_W'($urandom_range(255, 1)));
            2: draft.push_back(pick_operator());
            default: begin
              draft.push_back(CH_EQ);
              repeat ($urandom_range(3, 1)) begin
                draft.push_back(LRE_CH_W'($urandom_range(255, 1)));
              end
            end
          endcase
        end
      end else begin
        repeat ($urandom_range(8)) begin
          draft.push_back(LRE_CH_W'($urandom_range(255, 1)));
        end
      end
      made += commit_draft();
    end
  endtask

  // Waits until every character has gone and every result has come back.
  // It then waits out the block's longest internal step, so that a
  // register write lands on an idle block.
  task automatic settle();
    do begin
      @(posedge clk_i);
    end while (char_queue.size() != 0 || char_bus.valid || pending_verdicts.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes eval_enable with a setup and an access phase, then reads it back.
  task automatic write_enable(input logic en);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {LRE_REG_EVAL_ENABLE, 2'b00};
    pwdata  <= LRE_PDATA_W'(en);
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    eval_en = en;
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    if (prdata[0] !== en) begin
      $display("%0t: eval_enable read back, expected %0d, got %0d", $time, en, prdata[0]);
      errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Character driver and result-side back-pressure. Both change on the
  // falling edge. A character stays on the bus until a beat moves it.
  always @(negedge clk_i) begin
    if (!char_bus.valid || in_fire) begin
      if (char_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        char_bus.valid <= 1'b1;
        char_bus.ch    <= char_queue.pop_front();
      end else begin
        char_bus.valid <= 1'b0;
      end
    end
    result_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Monitor, sampling on the rising edge. Every character beat advances the
  // prediction. Every result beat is checked against the oldest expected
  // result.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= char_bus.valid && char_bus.ready;
      if (char_bus.valid && char_bus.ready) begin
        n_chars++;
        take_char(char_bus.ch);
      end
      if (result_bus.valid && result_bus.ready) begin
        n_results++;
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result beat, ok %0d value %0d", $time, result_bus.ok,
                   result_bus.value);
          errors++;
        end else begin
          want = pending_verdicts.pop_front();
          if (result_bus.ok !== want.ok) begin
            $display("%0t: ok mismatch, expected %0d, got %0d", $time, want.ok,
                     result_bus.ok);
            errors++;
          end
          if (result_bus.value !== want.value) begin
            $display("%0t: value mismatch, expected %0d (%h), got %0d (%h)", $time,
                     $signed(want.value), want.value, result_bus.value, result_bus.value);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog. A lost result also ends up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    char_bus.valid   = 1'b0;
    char_bus.ch      = '0;
    result_bus.ready = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    eval_en          = 1'b1;
    restart_expression();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed expressions. They cover the empty expression and a missing
    // operand. They also cover an unknown operator with the top character
    // code, division by zero and text after the '='. The last one is a
    // clean chain that uses every operator spelling but +.
    write_enable(1'b1);
    draft.delete();
    void'(commit_draft());
    add_text("7+");
    void'(commit_draft());
    draft.delete();
    add_text("9");
    draft.push_back(8'hff);
    void'(commit_draft());
    draft.delete();
    add_text("8/0");
    void'(commit_draft());
    draft.delete();
    add_text("5=3");
    void'(commit_draft());
    draft.delete();
    add_text("9*2x3X4/7-1=");
    void'(commit_draft());
    settle();

    // Sender idles a third of the time and the receiver stalls most of it.
    // The first part runs with evaluation disabled.
    write_enable(1'b0);
    fill_random(40);
    settle();
    write_enable(1'b1);
    fill_random(450);
    settle();

    // The same again the other way round, with a short disabled stretch.
    @(posedge clk_i);
    src_idle_pct  = 85;
    sink_idle_pct = 33;
    fill_random(400);
    settle();
    write_enable(1'b0);
    fill_random(40);
    settle();
    write_enable(1'b1);

    // Full rate on both sides.
    @(posedge clk_i);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    fill_random(400);
    settle();

    $display("tb: %0d characters in, %0d results checked (%0d ok, %0d with evaluation off)",
             n_chars, n_results, n_ok, n_disabled);
    $display("tb: %0d cycles, %0d mismatches", cycle_count, errors);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
